@@ rtl/edfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfq_pkg
// Types and constants shared by the EDF ready-queue scheduler modules.
// ----------------------------------------------------------------------------
package edfq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_ADVANCE  = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Command as classified by the front end.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] id;
    logic [31:0] deadline;
    logic [15:0] duration;
    logic [31:0] time_value;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] id;
    logic [31:0] deadline;
    logic [15:0] duration;
    logic [31:0] start_time;
    logic [31:0] time_now;
    logic [6:0]  queued;
  } result_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SCAN,
    EX_PICK,
    EX_SHIFT,
    EX_OUT
  } exec_state_e;

endpackage

@@ rtl/edfq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfq_front
// Input stage: unpacks transactions into commands and holds them in a short
// queue for the execution engine.
// ----------------------------------------------------------------------------
module edfq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [95:0]       s_data_i,
  input  logic [1:0]        s_user_i,
  output logic              c_valid_o,
  input  logic              c_ready_i,
  output edfq_pkg::cmd_t    c_cmd_o
);
  import edfq_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       in_cmd;
  logic       push, pop;

  always_comb begin
    in_cmd.cmd        = cmd_e'(s_user_i);
    in_cmd.id         = s_data_i[15:0];
    in_cmd.deadline   = s_data_i[47:16];
    in_cmd.duration   = s_data_i[63:48];
    in_cmd.time_value = s_data_i[95:64];
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign c_valid_o = (cnt_q != 2'd0);
  assign pop       = c_valid_o && c_ready_i;
  assign c_cmd_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_full_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !s_ready_o) else $error("ready while full");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (cnt_q != 2'd0)) else $error("pop from empty queue");
`endif

endmodule

@@ rtl/edfq_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfq_exec
// Execution engine: keeps the ready store in arrival order, scans it one
// entry per cycle for the earliest deadline, and compacts it after a dispatch.
// ----------------------------------------------------------------------------
module edfq_exec #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                c_valid_i,
  output logic                c_ready_o,
  input  edfq_pkg::cmd_t      c_cmd_i,
  output logic                r_valid_o,
  input  logic                r_ready_i,
  output edfq_pkg::result_t   r_result_o
);
  import edfq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [63:0] mem [QUEUE_DEPTH];   // {duration, deadline, id}

  exec_state_e state_q, state_d;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  logic [AW-1:0] best_q;
  logic [63:0]   best_e_q;
  logic [63:0]   rd_q;
  logic [31:0]   now_q;
  result_t       res_q;
  logic          rv_q;
  logic          cmd_v;

  logic [AW-1:0] rd_addr;
  logic          rd_en, better;
  logic [32:0]   sum;

  assign cmd_v     = c_valid_i && (state_q == EX_IDLE) && !rv_q;
  assign c_ready_o = cmd_v;
  assign r_valid_o = rv_q;
  assign r_result_o = res_q;

  // Candidate in rd_q wins over the best so far on a strictly smaller key.
  assign better = (rd_q[47:16] < best_e_q[47:16]) ||
                  ((rd_q[47:16] == best_e_q[47:16]) && (rd_q[15:0] < best_e_q[15:0]));
  assign sum = {1'b0, now_q} + {17'd0, best_e_q[63:48]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      EX_IDLE: begin
        if (cmd_v && c_cmd_i.cmd == CMD_DISPATCH && count_q != '0) state_d = EX_SCAN;
      end
      EX_SCAN: begin
        if (idx_q == count_q) state_d = EX_PICK;
      end
      EX_PICK:  state_d = EX_SHIFT;
      EX_SHIFT: begin
        if (idx_q == count_q) state_d = EX_OUT;
      end
      EX_OUT:   state_d = EX_IDLE;
      default:  state_d = EX_IDLE;
    endcase
  end

  // Read address: idle, entry 0; scan, idx_q; pick, best_q+1; shift, idx_q+2.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      EX_IDLE:  begin rd_en = 1'b1; rd_addr = '0; end
      EX_SCAN:  begin rd_en = 1'b1; rd_addr = idx_q[AW-1:0]; end
      EX_PICK:  begin rd_en = 1'b1; rd_addr = AW'(best_q + 1'b1); end
      EX_SHIFT: begin rd_en = 1'b1; rd_addr = AW'(idx_q + 2'd2); end
      default:  begin rd_en = 1'b0; rd_addr = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[rd_addr];
    if (cmd_v && c_cmd_i.cmd == CMD_PUSH && count_q < CW'(QUEUE_DEPTH)) begin
      mem[count_q[AW-1:0]] <= {c_cmd_i.duration, c_cmd_i.deadline, c_cmd_i.id};
    end else if (state_q == EX_SHIFT && idx_q + 1'b1 < count_q) begin
      mem[idx_q[AW-1:0]] <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EX_IDLE;
      count_q  <= '0;
      now_q    <= '0;
      rv_q     <= 1'b0;
      idx_q    <= '0;
      best_q   <= '0;
      best_e_q <= '0;
      res_q    <= '0;
    end else begin
      state_q <= state_d;
      if (rv_q && r_ready_i) rv_q <= 1'b0;
      case (state_q)
        EX_IDLE: begin
          if (cmd_v) begin
            res_q.status     <= ST_OK;
            res_q.id         <= '0;
            res_q.deadline   <= '0;
            res_q.duration   <= '0;
            res_q.start_time <= '0;
            case (c_cmd_i.cmd)
              CMD_PUSH: begin
                if (count_q < CW'(QUEUE_DEPTH)) begin
                  count_q      <= count_q + 1'b1;
                  res_q.queued <= 7'(count_q + 1'b1);
                end else begin
                  res_q.status <= ST_FULL;
                  res_q.queued <= 7'(count_q);
                end
                res_q.time_now <= now_q;
                rv_q <= 1'b1;
              end
              CMD_DISPATCH: begin
                if (count_q == '0) begin
                  res_q.status   <= ST_EMPTY;
                  res_q.time_now <= now_q;
                  res_q.queued   <= 7'(count_q);
                  rv_q <= 1'b1;
                end else begin
                  idx_q  <= CW'(1);
                  best_q <= '0;
                  best_e_q <= '1;  // replaced by entry 0 on first scan cycle
                end
              end
              CMD_ADVANCE: begin
                if (c_cmd_i.time_value > now_q) now_q <= c_cmd_i.time_value;
                res_q.time_now <= (c_cmd_i.time_value > now_q) ?
                                  c_cmd_i.time_value : now_q;
                res_q.queued   <= 7'(count_q);
                rv_q <= 1'b1;
              end
              default: begin
                res_q.time_now <= now_q;
                res_q.queued   <= 7'(count_q);
                rv_q <= 1'b1;
              end
            endcase
          end
        end
        EX_SCAN: begin
          // rd_q holds entry idx_q-1.
          if (idx_q == CW'(1) || better) begin
            best_e_q <= rd_q;
            best_q   <= AW'(idx_q - 1'b1);
          end
          if (idx_q != count_q) idx_q <= idx_q + 1'b1;
        end
        EX_PICK: begin
          idx_q <= CW'(best_q);
        end
        EX_SHIFT: begin
          if (idx_q != count_q) idx_q <= idx_q + 1'b1;
        end
        EX_OUT: begin
          count_q          <= count_q - 1'b1;
          now_q            <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          res_q.status     <= ST_OK;
          res_q.id         <= best_e_q[15:0];
          res_q.deadline   <= best_e_q[47:16];
          res_q.duration   <= best_e_q[63:48];
          res_q.start_time <= now_q;
          res_q.time_now   <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          res_q.queued     <= 7'(count_q - 1'b1);
          rv_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH)) else $error("count exceeds depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != EX_IDLE) |-> !c_ready_o) else $error("accept while busy");
  a_out_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EX_OUT) |=> r_valid_o) else $error("dispatch lost result");
`endif

endmodule

@@ rtl/edf_ready_queue_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_ready_queue_scheduler_top
// Non-preemptive earliest-deadline-first scheduler with a ready queue.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_axis channel, one per transaction, with the
// command code in tuser (push, dispatch, advance). Each command gives exactly
// one result transaction on m_axis. A small command queue decouples input
// from the execution engine, so the sender can hand over the next command
// while a result waits for the receiver.
// Push and advance load their result into the result register on acceptance.
// Dispatch scans the ready store one entry per cycle through its single read
// port, then compacts it one entry per cycle from the picked entry up; the
// compaction is longest when the oldest task is picked.
// The engine executes one command at a time.
// Reset clears the task count and the current time; store contents are not
// cleared and need no clearing pass. When the receiver stalls, the result
// holds and the engine waits; commands fill the two-entry queue, then
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module edf_ready_queue_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: task_id[15:0], task_deadline[47:16], task_duration[63:48],
  //        time_value[95:64]
  input  logic [95:0]  s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: out_id[15:0], out_deadline[47:16], out_duration[63:48],
  //        start_time[95:64], time_now[127:96], queued[134:128], zero pad
  output logic [135:0] m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser_o
);
  import edfq_pkg::*;

  logic    c_valid, c_ready;
  cmd_t    c_cmd;
  result_t res;

  edfq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .s_user_i  (s_axis_tuser_i),
    .c_valid_o (c_valid),
    .c_ready_i (c_ready),
    .c_cmd_o   (c_cmd)
  );

  edfq_exec #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .c_valid_i  (c_valid),
    .c_ready_o  (c_ready),
    .c_cmd_i    (c_cmd),
    .r_valid_o  (m_axis_tvalid_o),
    .r_ready_i  (m_axis_tready_i),
    .r_result_o (res)
  );

  assign m_axis_tuser_o = res.status;
  assign m_axis_tdata_o = {1'b0, res.queued, res.time_now, res.start_time,
                           res.duration, res.deadline, res.id};

endmodule
